// ===== rtl/keyed_running_max_table_assert.svh =====
// assertion macros for the keyed running maximum table
`ifndef KEYED_RUNNING_MAX_TABLE_ASSERT_SVH
`define KEYED_RUNNING_MAX_TABLE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked outside reset
`define KMT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kmt check failed");

// next-cycle implication, checked outside reset
`define KMT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kmt check failed");

`else

`define KMT_ASSERT_NOW(label, clk, rst, ante, cons)
`define KMT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/kmt_pkg.sv =====
`default_nettype none

package kmt_pkg;

  localparam int ENTRIES = 128;
  localparam int KEY_W   = 64;
  localparam int PRICE_W = 32;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int GROUP   = 16;
  localparam int NGROUPS = (ENTRIES + GROUP - 1) / GROUP;
  localparam int NPAD    = NGROUPS * GROUP;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_GATHER,
    S_RESOLVE
  } state_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic               cmp;
    logic               wr;
    logic [KEY_W-1:0]   key;
    logic [PRICE_W-1:0] price;
    logic [CNT_W-1:0]   count;
  } cell_req_t;

  // per-cell (and per-group) match report, value is zero without a hit
  typedef struct packed {
    logic               hit;
    logic [PRICE_W-1:0] value;
  } cell_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/keyed_running_max_table.sv =====
// flow: each accepted transaction passes through cell compare, group merge and resolve
//   before the output register is loaded; no new transaction is accepted until then,
//   and resolve waits while the output register still holds an unread result
// reset: rst (synchronous, active high) empties the table and clears the control;
//   key and maximum storage keeps no reset value and needs no clearing pass
`default_nettype none
`include "keyed_running_max_table_assert.svh"

module keyed_running_max_table (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [95:0] s_tdata,  // [63:0] key, [95:64] price
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata   // [31:0] highest, [32] new_key, [33] table_full, rest 0
);

  localparam int KW = kmt_pkg::KEY_W;
  localparam int PW = kmt_pkg::PRICE_W;
  localparam int CW = kmt_pkg::CNT_W;

  kmt_pkg::state_t state, state_next;

  // transaction being worked on
  logic [KW-1:0] key;
  logic [PW-1:0] price;

  // number of stored entries, the cells below it are live
  logic [CW-1:0] count;

  // output register
  logic [PW-1:0] highest;
  logic          new_key;
  logic          table_full;

  // control from the sequencer
  logic accept;
  logic load;
  logic grp_en;
  logic full;
  logic hit;
  logic [PW-1:0] hit_value;
  logic append;

  kmt_pkg::cell_req_t                         req;
  kmt_pkg::cell_rsp_t [kmt_pkg::NPAD-1:0]     cell_rsp;
  kmt_pkg::cell_rsp_t [kmt_pkg::NGROUPS-1:0]  grp_rsp;
  logic [kmt_pkg::NPAD-1:0]                   hit_vec;

  assign accept = s_tvalid && s_tready;
  assign full   = (count == CW'(kmt_pkg::ENTRIES));

  // final merge across the registered group results
  always_comb begin
    hit       = 1'b0;
    hit_value = '0;
    for (int g = 0; g < kmt_pkg::NGROUPS; g++) begin
      hit       = hit | grp_rsp[g].hit;
      hit_value = hit_value | grp_rsp[g].value;
    end
  end

  // sequencer: idle -> compare in every cell -> merge groups -> resolve
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    load       = 1'b0;
    grp_en     = 1'b0;
    case (state)
      kmt_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = kmt_pkg::S_CMP;
      end
      kmt_pkg::S_CMP: begin
        state_next = kmt_pkg::S_GATHER;
      end
      kmt_pkg::S_GATHER: begin
        grp_en     = 1'b1;
        state_next = kmt_pkg::S_RESOLVE;
      end
      kmt_pkg::S_RESOLVE: begin
        // the result waits here while the previous one is still unread
        if (!m_tvalid || m_tready) begin
          load       = 1'b1;
          state_next = kmt_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = kmt_pkg::S_IDLE;
      end
    endcase
  end

  // a miss with room left appends at the cell indexed by count
  assign append = load && !hit && !full;

  always_comb begin
    req.cmp   = (state == kmt_pkg::S_CMP);
    req.wr    = append;
    req.key   = key;
    req.price = price;
    req.count = count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kmt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key   <= s_tdata[63:0];
      price <= s_tdata[95:64];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (append) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // result payload: the maximum as raised by this price on a hit, else the price itself
  always_ff @(posedge clk) begin
    if (load) begin
      highest    <= hit ? hit_value : price;
      new_key    <= !hit;
      table_full <= !hit && full;
    end
  end

  assign m_tdata = {6'b0, table_full, new_key, highest};

  // row of entry cells, padded with idle slots up to whole groups
  for (genvar i = 0; i < kmt_pkg::NPAD; i++) begin : g_cell
    if (i < kmt_pkg::ENTRIES) begin : g_live
      kmt_cell u_cell (
        .clk (clk),
        .rst (rst),
        .idx (CW'(i)),
        .req (req),
        .rsp (cell_rsp[i])
      );
    end else begin : g_pad
      assign cell_rsp[i] = '0;
    end
  end

  for (genvar g = 0; g < kmt_pkg::NGROUPS; g++) begin : g_grp
    kmt_group u_group (
      .clk    (clk),
      .rst    (rst),
      .en     (grp_en),
      .cells  (cell_rsp[g*kmt_pkg::GROUP +: kmt_pkg::GROUP]),
      .merged (grp_rsp[g])
    );
  end

  always_comb begin
    for (int i = 0; i < kmt_pkg::NPAD; i++) begin
      hit_vec[i] = cell_rsp[i].hit;
    end
  end

  // keys are unique in the table, so no two cells may hit together
  `KMT_ASSERT_NOW(a_single_hit, clk, rst, 1'b1, $onehot0(hit_vec))
  // the fill count never runs past the table size
  `KMT_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CW'(kmt_pkg::ENTRIES))
  // a full flag only ever comes with a new key
  `KMT_ASSERT_NOW(a_full_is_new, clk, rst, m_tvalid && table_full, new_key)
  // an append grows the table by exactly one entry
  `KMT_ASSERT_NEXT(a_append_step, clk, rst, append, count == $past(count) + CW'(1))

endmodule

`default_nettype wire

// ===== rtl/kmt_cell.sv =====
`default_nettype none

module kmt_cell (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic [kmt_pkg::CNT_W-1:0] idx,
  input  wire kmt_pkg::cell_req_t      req,
  output kmt_pkg::cell_rsp_t           rsp
);

  logic [kmt_pkg::KEY_W-1:0]   key_q;
  logic [kmt_pkg::PRICE_W-1:0] max_q;
  logic                        occupied;
  logic                        match;
  logic [kmt_pkg::PRICE_W-1:0] bigger;

  always_comb begin
    occupied = idx < req.count;
    match    = req.cmp && occupied && (key_q == req.key);
    bigger   = (req.price > max_q) ? req.price : max_q;
  end

  // entry storage, written on append or raised on a hit
  always_ff @(posedge clk) begin
    if (req.wr && (idx == req.count)) begin
      key_q <= req.key;
      max_q <= req.price;
    end else if (match) begin
      max_q <= bigger;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp <= '0;
    end else begin
      rsp.hit   <= match;
      rsp.value <= match ? bigger : '0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/kmt_group.sv =====
`default_nettype none

module kmt_group (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  en,
  input  wire kmt_pkg::cell_rsp_t [kmt_pkg::GROUP-1:0] cells,
  output kmt_pkg::cell_rsp_t                         merged
);

  kmt_pkg::cell_rsp_t acc;

  // at most one cell hits, so an or of the gated values picks it
  always_comb begin
    acc = '0;
    for (int k = 0; k < kmt_pkg::GROUP; k++) begin
      acc.hit   = acc.hit | cells[k].hit;
      acc.value = acc.value | cells[k].value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      merged <= '0;
    end else if (en) begin
      merged <= acc;
    end
  end

endmodule

`default_nettype wire
